// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge outside reset
`define SIP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// check an implication at every clock edge outside reset
`define SIP_ASSERT_IMPL(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

`endif

// ===== rtl/sip24_pkg.sv =====
`timescale 1ns / 1ps

package sip24_pkg;

    localparam int LANE_W  = 64;
    localparam int PADDR_W = 4;

    localparam logic [LANE_W-1:0] SIP_C0    = 64'h736f6d6570736575;
    localparam logic [LANE_W-1:0] SIP_C1    = 64'h646f72616e646f6d;
    localparam logic [LANE_W-1:0] SIP_C2    = 64'h6c7967656e657261;
    localparam logic [LANE_W-1:0] SIP_C3    = 64'h7465646279746573;
    localparam logic [LANE_W-1:0] FINAL_XOR = 64'h00000000000000ff;

    localparam int ROT_13 = 13;
    localparam int ROT_16 = 16;
    localparam int ROT_17 = 17;
    localparam int ROT_21 = 21;
    localparam int ROT_32 = 32;

    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [LANE_W-1:0] v0;
        logic [LANE_W-1:0] v1;
        logic [LANE_W-1:0] v2;
        logic [LANE_W-1:0] v3;
    } sip24_lanes_t;

    typedef struct packed {
        logic              valid;
        logic [LANE_W-1:0] digest;
    } sip24_res_t;

    function automatic logic [LANE_W-1:0] rotl(input logic [LANE_W-1:0] x, input int n);
        rotl = (x << n) | (x >> (LANE_W - n));
    endfunction

    function automatic logic [LANE_W-1:0] byte_mask(input logic [2:0] nbytes);
        byte_mask = ~({LANE_W{1'b1}} << {nbytes, 3'b000});
    endfunction

endpackage

// ===== rtl/sip24_round.sv =====
`timescale 1ns / 1ps

module sip24_round import sip24_pkg::*; (
    input  sip24_lanes_t lanes_in,
    output sip24_lanes_t lanes_out
);

    logic [LANE_W-1:0] a0;
    logic [LANE_W-1:0] b1;
    logic [LANE_W-1:0] c0;
    logic [LANE_W-1:0] a2;
    logic [LANE_W-1:0] b3;
    logic [LANE_W-1:0] d0;
    logic [LANE_W-1:0] d2;

    always_comb begin
        a0 = lanes_in.v0 + lanes_in.v1;
        b1 = rotl(lanes_in.v1, ROT_13) ^ a0;
        c0 = rotl(a0, ROT_32);
        a2 = lanes_in.v2 + lanes_in.v3;
        b3 = rotl(lanes_in.v3, ROT_16) ^ a2;
        d0 = c0 + b3;
        d2 = a2 + b1;
        lanes_out.v0 = d0;
        lanes_out.v3 = rotl(b3, ROT_21) ^ d0;
        lanes_out.v1 = rotl(b1, ROT_17) ^ d2;
        lanes_out.v2 = rotl(d2, ROT_32);
    end

endmodule

// ===== rtl/sip24_core.sv =====
`timescale 1ns / 1ps

module sip24_core import sip24_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [LANE_W-1:0] key_low,
    input  logic [LANE_W-1:0] key_high,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [LANE_W-1:0] s_msg_word,
    input  logic [2:0]        s_tail_bytes,
    input  logic              s_last_item,
    output sip24_res_t        res,
    input  logic              res_ready
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ABSORB = 2'd1;
    localparam logic [1:0] ST_FINAL  = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        rnd_reg, rnd_next;
    logic              open_reg, open_next;
    logic [7:0]        len_reg, len_next;
    logic              last_reg, last_next;
    logic [LANE_W-1:0] m_reg, m_next;
    sip24_lanes_t      lanes_reg, lanes_next;

    sip24_lanes_t      start_lanes;
    sip24_lanes_t      round_in;
    sip24_lanes_t      round_out;
    logic [7:0]        len_base;
    logic [7:0]        len_total;
    logic [LANE_W-1:0] msg_in;
    logic              in_fire;

    sip24_round u_round (
        .lanes_in  (round_in),
        .lanes_out (round_out)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;

    always_comb begin
        len_base  = open_reg ? len_reg : 8'd0;
        len_total = len_base + {5'd0, s_tail_bytes};
        if (s_last_item) begin
            msg_in = (s_msg_word & byte_mask(s_tail_bytes)) | {len_total, 56'd0};
        end else begin
            msg_in = s_msg_word;
        end
        if (open_reg) begin
            start_lanes = lanes_reg;
        end else begin
            start_lanes.v0 = SIP_C0 ^ key_low;
            start_lanes.v1 = SIP_C1 ^ key_high;
            start_lanes.v2 = SIP_C2 ^ key_low;
            start_lanes.v3 = SIP_C3 ^ key_high;
        end
        start_lanes.v3 = start_lanes.v3 ^ msg_in;
        round_in = (state_reg == ST_IDLE) ? start_lanes : lanes_reg;
    end

    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        open_next  = open_reg;
        len_next   = len_reg;
        last_next  = last_reg;
        m_next     = m_reg;
        lanes_next = lanes_reg;
        res.valid  = 1'b0;
        res.digest = lanes_reg.v0 ^ lanes_reg.v1 ^ lanes_reg.v2 ^ lanes_reg.v3;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    lanes_next = round_out;
                    m_next     = msg_in;
                    last_next  = s_last_item;
                    open_next  = !s_last_item;
                    len_next   = s_last_item ? len_total : len_base + 8'd8;
                    state_next = ST_ABSORB;
                end
            end
            ST_ABSORB: begin
                lanes_next    = round_out;
                lanes_next.v0 = round_out.v0 ^ m_reg;
                rnd_next      = 2'd0;
                if (last_reg) begin
                    lanes_next.v2 = round_out.v2 ^ FINAL_XOR;
                    state_next    = ST_FINAL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FINAL: begin
                lanes_next = round_out;
                rnd_next   = rnd_reg + 2'd1;
                if (rnd_reg == 2'd3) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                res.valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= 2'd0;
            open_reg  <= 1'b0;
            len_reg   <= 8'd0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            open_reg  <= open_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg  <= last_next;
        m_reg     <= m_next;
        lanes_reg <= lanes_next;
    end

endmodule

// ===== rtl/siphash24_stream_hasher_top.sv =====
`timescale 1ns / 1ps

// Keyed SipHash-2-4 over a message streamed as 64-bit little-endian words.
// Input channel s_*: one word per handshake; s_last_item marks the final
// word, whose low s_tail_bytes bytes are kept and the rest masked off.
// Result channel m_*: one 64-bit digest per message, after its last word.
// Key: key_low at byte address 0, key_high at byte address 8, written over
// the APB port; the user writes them only while no message is in flight,
// which the block does not enforce; pready is always high.
// Throughput: one SipRound per cycle in the shared round unit. Each word
// gets 2 compression rounds, at acceptance and in ABSORB; a last word then
// gets 4 finalization rounds in FINAL, and DONE moves the digest into the
// output register (m_valid) once it is free; s_ready is low until IDLE again.
// Stall: the output register holds the digest while m_ready is low; new
// words are still taken until a further digest is done and waits in DONE.
// Reset (aresetn low, synchronous): keys clear to zero, any open message is
// dropped and the output register empties.
module siphash24_stream_hasher_top import sip24_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [LANE_W-1:0]  pwdata,
    output logic [LANE_W-1:0]  prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [LANE_W-1:0]  s_msg_word,
    input  logic [2:0]         s_tail_bytes,
    input  logic               s_last_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LANE_W-1:0]  m_digest
);

    logic [LANE_W-1:0] key_low_reg;
    logic [LANE_W-1:0] key_high_reg;
    logic              out_valid_reg, out_valid_next;
    logic [LANE_W-1:0] digest_reg, digest_next;
    sip24_res_t        res;
    logic              res_ready;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = (paddr[3] == REG_KEY_HIGH) ? key_high_reg : key_low_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else if (wr_en) begin
            if (paddr[3] == REG_KEY_HIGH) begin
                key_high_reg <= pwdata;
            end else begin
                key_low_reg <= pwdata;
            end
        end
    end

    sip24_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .key_low      (key_low_reg),
        .key_high     (key_high_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_msg_word   (s_msg_word),
        .s_tail_bytes (s_tail_bytes),
        .s_last_item  (s_last_item),
        .res          (res),
        .res_ready    (res_ready)
    );

    assign res_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        digest_next    = digest_reg;
        if (res.valid && res_ready) begin
            out_valid_next = 1'b1;
            digest_next    = res.digest;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        digest_reg <= digest_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_digest = digest_reg;

endmodule

// ===== rtl/sip24_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sip24_checker import sip24_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_last_item,
    input logic               m_valid,
    input logic               m_ready,
    input logic [LANE_W-1:0]  m_digest
);

    `SIP_ASSERT_IMPL(a_busy_after_word, (s_valid && s_ready |=> !s_ready), "ready after accept")
    `SIP_ASSERT_IMPL(a_word_two_cycles, (s_valid && s_ready && !s_last_item |=> ##1 s_ready), "word not done in two cycles")
    `SIP_ASSERT_IMPL(a_digest_latency, (s_valid && s_ready && s_last_item && !m_valid |-> ##7 m_valid), "digest late")
    `SIP_ASSERT_IMPL(a_digest_hold, (m_valid && !m_ready |=> m_valid && $stable(m_digest)), "stalled digest changed")

endmodule

bind siphash24_stream_hasher_top sip24_checker u_sip24_checker (.*);

// ===== tb/sv/siphash24_stream_hasher_top_tb.sv =====
`timescale 1ns / 1ps

module siphash24_stream_hasher_top_tb import sip24_pkg::*;;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [PADDR_W-1:0] ADDR_KEY_LOW  = {REG_KEY_LOW, 3'b000};
    localparam logic [PADDR_W-1:0] ADDR_KEY_HIGH = {REG_KEY_HIGH, 3'b000};

    logic               aclk;
    logic               aresetn      = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [LANE_W-1:0]  pwdata       = '0;
    logic [LANE_W-1:0]  prdata;
    logic               pready;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [LANE_W-1:0]  s_msg_word   = '0;
    logic [2:0]         s_tail_bytes = '0;
    logic               s_last_item  = 1'b0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic [LANE_W-1:0]  m_digest;

    siphash24_stream_hasher_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_msg_word   (s_msg_word),
        .s_tail_bytes (s_tail_bytes),
        .s_last_item  (s_last_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digest     (m_digest)
    );

    sip24_lanes_t      sip_lanes  = '0;
    logic [7:0]        byte_count = '0;
    logic              msg_open   = 1'b0;
    logic [LANE_W-1:0] key0       = '0;
    logic [LANE_W-1:0] key1       = '0;

    logic [LANE_W-1:0] digest_q[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_left       = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [LANE_W-1:0] got,
                                   input logic [LANE_W-1:0] want);
        $display("MISMATCH at cycle %0d, %s: got %h, want %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                report_mismatch("digest with no message closed", m_digest, '0);
            end else if (m_digest !== digest_q[0]) begin
                report_mismatch("digest", m_digest, digest_q.pop_front());
            end else begin
                void'(digest_q.pop_front());
            end
        end
    end

    function automatic logic [LANE_W-1:0] rot_left(input logic [LANE_W-1:0] x, input int n);
        logic [2*LANE_W-1:0] dbl;
        dbl = {x, x} << n;
        return dbl[2*LANE_W-1:LANE_W];
    endfunction

    function automatic sip24_lanes_t mix_round(input sip24_lanes_t s);
        sip24_lanes_t r;
        r = s;
        r.v0 = r.v0 + r.v1;
        r.v1 = rot_left(r.v1, ROT_13) ^ r.v0;
        r.v0 = rot_left(r.v0, ROT_32);
        r.v2 = r.v2 + r.v3;
        r.v3 = rot_left(r.v3, ROT_16) ^ r.v2;
        r.v0 = r.v0 + r.v3;
        r.v3 = rot_left(r.v3, ROT_21) ^ r.v0;
        r.v2 = r.v2 + r.v1;
        r.v1 = rot_left(r.v1, ROT_17) ^ r.v2;
        r.v2 = rot_left(r.v2, ROT_32);
        return r;
    endfunction

    function automatic sip24_lanes_t compress(input sip24_lanes_t s, input logic [LANE_W-1:0] m);
        sip24_lanes_t r;
        r = s;
        r.v3 = r.v3 ^ m;
        r = mix_round(mix_round(r));
        r.v0 = r.v0 ^ m;
        return r;
    endfunction

    task automatic predict_digest(input logic [LANE_W-1:0] w, input logic [2:0] t, input logic l);
        logic [LANE_W-1:0] keep;
        logic [LANE_W-1:0] m;
        logic [7:0]        total;
        if (!msg_open) begin
            sip_lanes.v0 = SIP_C0 ^ key0;
            sip_lanes.v1 = SIP_C1 ^ key1;
            sip_lanes.v2 = SIP_C2 ^ key0;
            sip_lanes.v3 = SIP_C3 ^ key1;
            byte_count = '0;
            msg_open = 1'b1;
        end
        if (!l) begin
            sip_lanes = compress(sip_lanes, w);
            byte_count = byte_count + 8'd8;
        end else begin
            keep = ~({LANE_W{1'b1}} << (8 * int'(t)));
            total = byte_count + 8'(t);
            m = (w & keep) | {total, 56'h0};
            sip_lanes = compress(sip_lanes, m);
            sip_lanes.v2 = sip_lanes.v2 ^ FINAL_XOR;
            repeat (4) sip_lanes = mix_round(sip_lanes);
            digest_q.push_back(sip_lanes.v0 ^ sip_lanes.v1 ^ sip_lanes.v2 ^ sip_lanes.v3);
            byte_count = total;
            msg_open = 1'b0;
        end
    endtask

    task automatic send_word(input logic [LANE_W-1:0] w, input logic [2:0] t, input logic l);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_msg_word   <= w;
        s_tail_bytes <= t;
        s_last_item  <= l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_digest(w, t, l);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (digest_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [LANE_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        if (prdata !== data) report_mismatch("key readback", prdata, data);
    endtask

    task automatic write_keys(input logic [LANE_W-1:0] lo, input logic [LANE_W-1:0] hi);
        apb_write(ADDR_KEY_LOW, lo);
        key0 = lo;
        apb_write(ADDR_KEY_HIGH, hi);
        key1 = hi;
    endtask

    function automatic logic [LANE_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_msg_len();
        int r;
        r = $urandom_range(99);
        if (r < 85) return $urandom_range(6);
        if (r < 97) return $urandom_range(20, 7);
        return $urandom_range(40, 30);
    endfunction

    task automatic send_message(input int nwords);
        for (int i = 0; i < nwords; i++) send_word(rand_word(), 3'($urandom_range(7)), 1'b0);
        send_word(rand_word(), 3'($urandom_range(7)), 1'b1);
    endtask

    task automatic test_empty_message();
        sender_idle_pct = 30;
        recv_stall_pct  = 30;
        send_word({LANE_W{1'b1}}, 3'd0, 1'b1);
        send_word('0, 3'd0, 1'b1);
        wait_idle();
    endtask

    task automatic test_tail_masking();
        for (int t = 1; t < 8; t++) send_word({LANE_W{1'b1}}, 3'(t), 1'b1);
        wait_idle();
    endtask

    task automatic test_word_extremes();
        send_word('0, 3'd0, 1'b0);
        send_word({LANE_W{1'b1}}, 3'd7, 1'b0);
        send_word({LANE_W{1'b1}}, 3'd7, 1'b1);
        wait_idle();
    endtask

    task automatic test_tail_ignored_nonlast();
        send_word(rand_word(), 3'd7, 1'b0);
        send_word(rand_word(), 3'd3, 1'b0);
        send_word(rand_word(), 3'd0, 1'b1);
        wait_idle();
    endtask

    task automatic test_known_vector();
        write_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
        send_word(64'h0706050403020100, 3'd5, 1'b0);
        send_word(64'hff0e0d0c0b0a0908, 3'd7, 1'b1);
        if (digest_q[$] !== 64'ha129ca6149be45e5)
            report_mismatch("digest model self-check", digest_q[$], 64'ha129ca6149be45e5);
        wait_idle();
    endtask

    task automatic test_key_change_mid_message();
        send_word(rand_word(), 3'd0, 1'b0);
        send_word(rand_word(), 3'd1, 1'b0);
        wait_idle();
        write_keys({LANE_W{1'b1}}, {LANE_W{1'b1}});
        send_word(rand_word(), 3'd4, 1'b1);
        send_word(rand_word(), 3'd2, 1'b1);
        wait_idle();
    endtask

    task automatic test_backpressure();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_left = 300;
        for (int i = 0; i < 6; i++) send_message(2);
        wait_idle();
    endtask

    task automatic run_random_phase(input int sidle, input int rstall, input int items);
        int sent;
        int msgs;
        int n;
        sent = 0;
        msgs = 0;
        sender_idle_pct = sidle;
        recv_stall_pct  = rstall;
        while (sent < items) begin
            n = pick_msg_len();
            send_message(n);
            sent += n + 1;
            msgs++;
            if (msgs % 40 == 0) wait_idle();
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        write_keys(rand_word(), rand_word());
        run_random_phase(0, 0, 400);
        write_keys({LANE_W{1'b1}}, '0);
        run_random_phase(65, 0, 400);
        write_keys('0, {LANE_W{1'b1}});
        run_random_phase(0, 65, 400);
        write_keys(rand_word(), rand_word());
        run_random_phase(14, 14, 400);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_message();
        test_tail_masking();
        test_word_extremes();
        test_tail_ignored_nonlast();
        test_known_vector();
        test_key_change_mid_message();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (digest_q.size() != 0) report_mismatch("digests never delivered", '0, digest_q[0]);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sip24_pkg.sv
rtl/sip24_round.sv
rtl/sip24_core.sv
rtl/siphash24_stream_hasher_top.sv
rtl/sip24_checker.sv
tb/sv/siphash24_stream_hasher_top_tb.sv
